[design/mma_pkg.sv]
// Shared constants, register codes and arithmetic command types for the
// multichannel moving average. No dependencies.
package mma_pkg;

  localparam int CHANNELS_DEF    = 4;
  localparam int MAX_WINDOW_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths of the ports.
  localparam int CHAN_W      = 2;
  localparam int SAMPLE_W    = 16;
  localparam int MEAN_W      = 16;
  localparam int ACTIVE_W    = 3;
  localparam int WINDOW_W    = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  localparam int NUM_REGS     = 5;
  localparam int NUM_WIN_REGS = 4;
  localparam int WIN_SEL_W    = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN0   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN1   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN2   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WIN3   = 3'd4;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 3'd4;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd8;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLR,
    OP_ACC,
    OP_LOAD,
    OP_STEP
  } arith_op_t;

  typedef struct packed {
    arith_op_t op;
    logic      keep;
  } arith_cmd_t;

endpackage

[design/multichannel_moving_average.sv]
// Top level of the multichannel moving average: configuration registers,
// per-channel ring pointers and the sequencer. Depends on mma_pkg, mma_store
// and mma_arith.
//
// Usage: a beat on the in_ channel carries a sample and its channel number.
// The block writes the sample into that channel's ring of window slots, sums
// the window through one shared adder and divides by the window length with
// the same adder, one quotient bit per cycle. Every input beat yields exactly
// one out_ beat carrying the channel, the truncated mean and a flag for a
// channel at or above the active count (mean zero, nothing changed).
// A valid sample passes through the write, read, load and divide states to
// the finish state, which fills the result register. The divide yields
// SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW) quotient bits. A flagged channel
// goes straight from idle to the finish state. in_ready is high only while
// the sequencer is idle, so the block takes one beat at a time and accepts
// no new sample until it is through with the last. The result register
// lets the next sample be accepted while a result waits; if the receiver
// still stalls when the next result is done, the sequencer holds until
// out_ready.
// Reset and writes to indices below NUM_REGS empty all windows via per-channel
// fill counters, so no clearing pass is needed; unwritten slots read as zero.
module multichannel_moving_average #(
  parameter int CHANNELS    = mma_pkg::CHANNELS_DEF,
  parameter int MAX_WINDOW  = mma_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mma_pkg::CHAN_W-1:0]       in_channel,
  input  logic [mma_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mma_pkg::CHAN_W-1:0]       out_channel,
  output logic [mma_pkg::MEAN_W-1:0]       out_mean_value,
  output logic                             out_bad_channel,
  input  logic                             cfg_we,
  input  logic [mma_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mma_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int IDX_W     = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int STEP_W    = $clog2(SUM_W);
  localparam int DEPTH     = CHANNELS * MAX_WINDOW;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CHAN_W    = mma_pkg::CHAN_W;
  localparam int MEAN_W    = mma_pkg::MEAN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_READ,
    S_LOAD,
    S_DIV,
    S_FIN
  } state_t;

  // Configuration.
  logic [mma_pkg::ACTIVE_W-1:0] active_r;
  logic [mma_pkg::WINDOW_W-1:0] win_r [mma_pkg::NUM_WIN_REGS];
  logic                         cfg_clear;
  logic [mma_pkg::CFG_INDEX_W-1:0] win_pick;

  // Per-channel ring state.
  logic [IDX_W-1:0] idx_r  [CHANNELS];
  logic [CNT_W-1:0] fill_r [CHANNELS];

  // Sequencer.
  state_t                 state_r, state_nxt;
  logic [CHAN_W-1:0]      ch_r, ch_nxt;
  logic [SAMPLE_BITS-1:0] smp_r, smp_nxt;
  logic                   bad_r, bad_nxt;
  logic [CNT_W-1:0]       w_r, w_nxt;
  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   rd_ok_r, rd_ok_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]      out_channel_r, out_channel_nxt;
  logic [MEAN_W-1:0]      out_mean_r, out_mean_nxt;
  logic                   out_bad_r, out_bad_nxt;

  logic                         in_fire;
  logic                         in_bad;
  logic [mma_pkg::WINDOW_W-1:0] w_raw;
  logic [CNT_W-1:0]             w_eff;
  logic [CH_W+CHAN_W-1:0]       ch_ext;
  logic [CH_W-1:0]              ch_idx;
  logic [CNT_W-1:0]             idx_cur, slot, slot_inc;
  logic [IDX_W-1:0]             idx_nxt;
  logic [CNT_W-1:0]             fill_cur, fill_nxt;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr, mem_raddr;
  logic [SAMPLE_BITS-1:0]       mem_rdata;
  mma_pkg::arith_cmd_t          cmd;
  logic [SUM_W-1:0]             quotient;
  logic [SUM_W+MEAN_W-1:0]      quo_ext;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  assign cfg_clear = cfg_we && (32'(cfg_index) < mma_pkg::NUM_REGS);
  assign win_pick  = cfg_index - mma_pkg::CFG_INDEX_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= mma_pkg::ACTIVE_RESET;
      for (int i = 0; i < mma_pkg::NUM_WIN_REGS; i++) begin
        win_r[i] <= mma_pkg::WINDOW_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        mma_pkg::REG_ACTIVE: begin
          active_r <= cfg_data[mma_pkg::ACTIVE_W-1:0];
        end
        mma_pkg::REG_WIN0, mma_pkg::REG_WIN1, mma_pkg::REG_WIN2, mma_pkg::REG_WIN3: begin
          win_r[win_pick[mma_pkg::WIN_SEL_W-1:0]] <= cfg_data[mma_pkg::WINDOW_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Acceptance checks and window length of the offered channel.
  // ---------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_bad   = (32'(in_channel) >= 32'(active_r)) || (32'(in_channel) >= CHANNELS);
  assign w_raw    = win_r[in_channel];

  always_comb begin
    if (w_raw == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(w_raw) > MAX_WINDOW) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(w_raw);
    end
  end

  // ---------------------------------------------------------------------
  // Ring pointer and fill count of the channel at work.
  // ---------------------------------------------------------------------
  assign ch_ext   = {{CH_W{1'b0}}, ch_r};
  assign ch_idx   = ch_ext[CH_W-1:0];
  assign idx_cur  = CNT_W'(idx_r[ch_idx]);
  assign fill_cur = fill_r[ch_idx];
  assign slot     = (idx_cur >= w_r) ? '0 : idx_cur;
  assign slot_inc = slot + CNT_W'(1);
  assign idx_nxt  = (slot_inc >= w_r) ? '0 : slot_inc[IDX_W-1:0];
  assign fill_nxt = (fill_cur < w_r) ? fill_cur + CNT_W'(1) : fill_cur;

  // The window always fills from slot zero upward after a clear, so slots
  // at or above the fill count have never been written and count as zero.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_clear) begin
      for (int i = 0; i < CHANNELS; i++) begin
        idx_r[i]  <= '0;
        fill_r[i] <= '0;
      end
    end else if (state_r == S_WRITE) begin
      idx_r[ch_idx]  <= idx_nxt;
      fill_r[ch_idx] <= fill_nxt;
    end
  end

  assign mem_we    = (state_r == S_WRITE);
  assign mem_waddr = ADDR_W'(32'(ch_idx) * MAX_WINDOW + 32'(slot));
  assign mem_raddr = ADDR_W'(32'(ch_idx) * MAX_WINDOW + 32'(n_r));

  mma_store #(
    .DEPTH  (DEPTH),
    .DATA_W (SAMPLE_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (smp_r),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mma_arith #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W)
  ) u_arith (
    .clk      (clk),
    .cmd      (cmd),
    .addend   (mem_rdata),
    .divisor  (w_r),
    .quotient (quotient)
  );

  assign quo_ext = {{MEAN_W{1'b0}}, quotient};

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt       = state_r;
    ch_nxt          = ch_r;
    smp_nxt         = smp_r;
    bad_nxt         = bad_r;
    w_nxt           = w_r;
    n_nxt           = n_r;
    rd_ok_nxt       = rd_ok_r;
    step_nxt        = step_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_channel_nxt = out_channel_r;
    out_mean_nxt    = out_mean_r;
    out_bad_nxt     = out_bad_r;
    cmd.op          = mma_pkg::OP_HOLD;
    cmd.keep        = rd_ok_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ch_nxt    = in_channel;
          smp_nxt   = in_sample[SAMPLE_BITS-1:0];
          bad_nxt   = in_bad;
          w_nxt     = w_eff;
          state_nxt = in_bad ? S_FIN : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.op    = mma_pkg::OP_CLR;
        n_nxt     = '0;
        state_nxt = S_READ;
      end
      S_READ: begin
        // Slot n is addressed now; its data is added in the next cycle.
        rd_ok_nxt = (n_r < fill_cur);
        if (n_r != '0) begin
          cmd.op = mma_pkg::OP_ACC;
        end
        if (n_r == w_r) begin
          state_nxt = S_LOAD;
        end else begin
          n_nxt = n_r + CNT_W'(1);
        end
      end
      S_LOAD: begin
        cmd.op    = mma_pkg::OP_LOAD;
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = mma_pkg::OP_STEP;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = S_FIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_channel_nxt = ch_r;
          out_mean_nxt    = bad_r ? '0 : quo_ext[MEAN_W-1:0];
          out_bad_nxt     = bad_r;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ch_r          <= ch_nxt;
    smp_r         <= smp_nxt;
    bad_r         <= bad_nxt;
    w_r           <= w_nxt;
    n_r           <= n_nxt;
    rd_ok_r       <= rd_ok_nxt;
    step_r        <= step_nxt;
    out_channel_r <= out_channel_nxt;
    out_mean_r    <= out_mean_nxt;
    out_bad_r     <= out_bad_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_channel_r;
  assign out_mean_value  = out_mean_r;
  assign out_bad_channel = out_bad_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_bad_mean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_channel |-> out_mean_value == '0)
    else $error("flagged channel reported a nonzero mean");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is still in work");

  a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_READ |-> idx_cur < w_r && fill_cur <= w_r && fill_cur != '0)
    else $error("ring pointer or fill count outside the window");

  a_fin_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == S_FIN) && !bad_r |-> $past(state_r) == S_DIV)
    else $error("result finished without a full divide");

endmodule

[design/mma_store.sv]
// Sample store of the moving average: one write port and one read port
// with registered read data. No dependencies.
module mma_store #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/mma_arith.sv]
// Shared add/subtract unit with its accumulator and quotient registers.
// It sums the window and then runs a restoring divide one bit per cycle.
// Depends on mma_pkg.
module mma_arith #(
  parameter int SAMPLE_BITS = mma_pkg::SAMPLE_BITS_DEF,
  parameter int SUM_W       = 20,
  parameter int CNT_W       = 5
) (
  input  logic                   clk,
  input  mma_pkg::arith_cmd_t    cmd,
  input  logic [SAMPLE_BITS-1:0] addend,
  input  logic [CNT_W-1:0]       divisor,
  output logic [SUM_W-1:0]       quotient
);

  localparam int AW = SUM_W + 2;

  logic [SUM_W-1:0] acc_r, acc_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [AW-1:0]    op_a, op_b, res;
  logic             sub;
  logic             neg;

  always_comb begin
    op_a = '0;
    op_b = '0;
    sub  = 1'b0;
    case (cmd.op)
      mma_pkg::OP_ACC: begin
        op_a = {2'b00, acc_r};
        op_b = cmd.keep ? AW'(addend) : '0;
      end
      mma_pkg::OP_STEP: begin
        // Shift the next dividend bit into the partial remainder.
        op_a = {1'b0, acc_r, quo_r[SUM_W-1]};
        op_b = AW'(divisor);
        sub  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res = sub ? (op_a - op_b) : (op_a + op_b);
  assign neg = res[AW-1];

  always_comb begin
    acc_nxt = acc_r;
    quo_nxt = quo_r;
    case (cmd.op)
      mma_pkg::OP_CLR:  acc_nxt = '0;
      mma_pkg::OP_ACC:  acc_nxt = res[SUM_W-1:0];
      mma_pkg::OP_LOAD: begin
        quo_nxt = acc_r;
        acc_nxt = '0;
      end
      mma_pkg::OP_STEP: begin
        acc_nxt = neg ? op_a[SUM_W-1:0] : res[SUM_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], ~neg};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
  end

  assign quotient = quo_r;

endmodule

[tb/multichannel_moving_average_test.sv]
// Self-checking testbench for multichannel_moving_average: random and directed
// sample beats, per-channel window predictor, register writes between phases.
// Depends on mma_pkg and the multichannel_moving_average RTL.
`timescale 1ns / 1ps

module multichannel_moving_average_test;

  localparam int LANES        = mma_pkg::CHANNELS_DEF;
  localparam int RING_DEPTH   = mma_pkg::MAX_WINDOW_DEF;
  localparam int CHAN_W       = mma_pkg::CHAN_W;
  localparam int SAMPLE_W     = mma_pkg::SAMPLE_W;
  localparam int MEAN_W       = mma_pkg::MEAN_W;
  localparam int ACTIVE_W     = mma_pkg::ACTIVE_W;
  localparam int WINDOW_W     = mma_pkg::WINDOW_W;
  localparam int CFG_INDEX_W  = mma_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W   = mma_pkg::CFG_DATA_W;
  localparam int NUM_REGS     = mma_pkg::NUM_REGS;
  localparam int NUM_WIN_REGS = mma_pkg::NUM_WIN_REGS;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 4000;
  localparam int SETTLE_WAIT  = 60;
  localparam int REPORT_LIMIT = 10;
  localparam int RAND_PHASES  = 7;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] value;
  } sample_beat_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [MEAN_W-1:0] mean;
    logic              bad;
  } mean_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [CHAN_W-1:0]      in_channel = '0;
  logic [SAMPLE_W-1:0]    in_sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [CHAN_W-1:0]      out_channel;
  logic [MEAN_W-1:0]      out_mean_value;
  logic                   out_bad_channel;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Predictor state: configuration, per-channel rings and write pointers.
  logic [ACTIVE_W-1:0]    active_cfg;
  logic [WINDOW_W-1:0]    window_cfg [NUM_WIN_REGS];
  logic [SAMPLE_W-1:0]    ring [LANES][RING_DEPTH];
  int unsigned            ring_ptr [LANES];

  sample_beat_t           sample_queue[$];
  mean_result_t           mean_expected[$];
  int                     samples_queued = 0;
  int                     means_seen = 0;
  int                     errors = 0;
  int                     quiet_cycles = 0;
  int                     send_idle_pct = 0;
  int                     recv_stall_pct = 0;
  logic                   hold_armed = 1'b0;
  int                     hold_count = 0;
  logic                   in_taken;

  multichannel_moving_average dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_channel     (in_channel),
    .in_sample      (in_sample),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_mean_value (out_mean_value),
    .out_bad_channel(out_bad_channel),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_windows();
    for (int c = 0; c < LANES; c++) begin
      ring_ptr[c] = 0;
      for (int s = 0; s < RING_DEPTH; s++) ring[c][s] = '0;
    end
  endfunction

  // For a live channel, writes the sample into its ring and returns the truncated mean; else flags it.
  function automatic mean_result_t push_and_average(logic [CHAN_W-1:0] chan,
                                                    logic [SAMPLE_W-1:0] value);
    mean_result_t r;
    int unsigned  live;
    int unsigned  win;
    int unsigned  ptr;
    int unsigned  total;
    live = (active_cfg > LANES) ? LANES : active_cfg;
    r.chan = chan;
    r.mean = '0;
    r.bad  = 1'b1;
    if (chan >= live) return r;
    win = window_cfg[chan];
    if (win == 0) win = 1;
    if (win > RING_DEPTH) win = RING_DEPTH;
    ptr = ring_ptr[chan];
    if (ptr >= win) ptr = 0;
    ring[chan][ptr] = value;
    ptr++;
    if (ptr >= win) ptr = 0;
    ring_ptr[chan] = ptr;
    total = 0;
    for (int k = 0; k < win; k++) total += ring[chan][k];
    r.mean = MEAN_W'(total / win);
    r.bad  = 1'b0;
    return r;
  endfunction

  // The block is idle here, so the predictor can follow the write at once.
  task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx < NUM_REGS) begin
      if (idx == mma_pkg::REG_ACTIVE) active_cfg = data[ACTIVE_W-1:0];
      else window_cfg[idx - mma_pkg::REG_WIN0] = data;
      clear_windows();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (means_seen != samples_queued) @(negedge clk);
  endtask

  function automatic void queue_sample(logic [CHAN_W-1:0] chan,
                                       logic [SAMPLE_W-1:0] value);
    sample_beat_t b;
    b.chan  = chan;
    b.value = value;
    sample_queue.push_back(b);
    samples_queued++;
  endfunction

  // Mostly channels that are live, so most beats reach the window logic.
  task automatic run_random(int count, int s_idle, int r_stall);
    int unsigned live;
    logic [CHAN_W-1:0] chan;
    logic [SAMPLE_W-1:0] value;
    @(posedge clk);
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    live = (active_cfg > LANES) ? LANES : active_cfg;
    for (int n = 0; n < count; n++) begin
      if (live > 0 && $urandom_range(0, 9) < 8) chan = CHAN_W'($urandom_range(0, live - 1));
      else chan = CHAN_W'($urandom_range(0, LANES - 1));
      case ($urandom_range(0, 7))
        0:       value = '0;
        1:       value = '1;
        default: value = SAMPLE_W'($urandom_range(0, 65535));
      endcase
      queue_sample(chan, value);
    end
    wait_idle();
  endtask

  always @(negedge clk) begin : drive_samples
    sample_beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (sample_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        b = sample_queue.pop_front();
        in_valid   <= 1'b1;
        in_channel <= b.chan;
        in_sample  <= b.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // A long hold-off lets the result register and the sequencer fill up.
  always @(negedge clk) begin
    if (hold_armed && hold_count < HOLD_CYCLES) begin
      out_ready  <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    mean_result_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      means_seen++;
      if (mean_expected.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result beat: channel %0d mean %0d bad %0b",
                   out_channel, out_mean_value, out_bad_channel);
      end else begin
        want = mean_expected.pop_front();
        if (out_channel !== want.chan || out_mean_value !== want.mean ||
            out_bad_channel !== want.bad) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("mismatch: channel %0d/%0d mean %0d/%0d bad %0b/%0b (expected/actual)",
                     want.chan, out_channel, want.mean, out_mean_value,
                     want.bad, out_bad_channel);
        end
      end
    end
    if (rst_n && in_valid && in_ready)
      mean_expected.push_back(push_and_average(in_channel, in_sample));
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned mode;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    active_cfg = mma_pkg::ACTIVE_RESET;
    for (int c = 0; c < NUM_WIN_REGS; c++) window_cfg[c] = mma_pkg::WINDOW_RESET;
    clear_windows();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: channel zero wraps its window of eight with full-scale
    // samples, the others see the sample extremes.
    @(posedge clk);
    for (int n = 0; n < 9; n++) queue_sample(2'd0, 16'hFFFF);
    queue_sample(2'd1, 16'h0001);
    queue_sample(2'd2, 16'hAAAA);
    queue_sample(2'd3, 16'h5555);
    queue_sample(2'd1, 16'h8000);
    queue_sample(2'd2, 16'hFFFF);
    queue_sample(2'd3, 16'h0000);
    queue_sample(2'd0, 16'h1234);
    wait_idle();

    // One live channel; window of one, the largest, zero and out of range.
    set_reg(mma_pkg::REG_ACTIVE, 5'd1);
    set_reg(mma_pkg::REG_WIN0, 5'd1);
    set_reg(mma_pkg::REG_WIN1, 5'd16);
    set_reg(mma_pkg::REG_WIN2, 5'd0);
    set_reg(mma_pkg::REG_WIN3, 5'd31);
    run_random(90, 0, 0);

    // Active count above the channel count acts as all channels.
    set_reg(mma_pkg::REG_ACTIVE, 5'd7);
    set_reg(mma_pkg::REG_WIN0, 5'd16);
    set_reg(mma_pkg::REG_WIN1, 5'd2);
    set_reg(mma_pkg::REG_WIN2, 5'd17);
    set_reg(mma_pkg::REG_WIN3, 5'd1);
    run_random(120, 67, 0);

    // With no live channel every beat is flagged.
    set_reg(mma_pkg::REG_ACTIVE, 5'd0);
    run_random(30, 0, 67);

    // Upper data bits of the active count are dropped; unlisted registers
    // must leave the windows as they are.
    set_reg(mma_pkg::REG_ACTIVE, 5'd12);
    for (int c = 0; c < NUM_WIN_REGS; c++)
      set_reg(CFG_INDEX_W'(mma_pkg::REG_WIN0 + c),
              CFG_DATA_W'($urandom_range(1, RING_DEPTH)));
    run_random(60, 33, 33);
    for (int r = NUM_REGS; r < (1 << CFG_INDEX_W); r++)
      set_reg(CFG_INDEX_W'(r), CFG_DATA_W'($urandom_range(0, 31)));
    run_random(60, 33, 33);

    // Receiver holds off while the sender keeps offering beats.
    for (int c = 0; c < NUM_WIN_REGS; c++)
      set_reg(CFG_INDEX_W'(mma_pkg::REG_WIN0 + c), 5'd16);
    @(posedge clk);
    hold_armed = 1'b1;
    run_random(80, 0, 0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if ($urandom_range(0, 9) < 8)
        set_reg(mma_pkg::REG_ACTIVE, CFG_DATA_W'($urandom_range(1, LANES)));
      else set_reg(mma_pkg::REG_ACTIVE, CFG_DATA_W'($urandom_range(0, 31)));
      for (int c = 0; c < NUM_WIN_REGS; c++) begin
        if ($urandom_range(0, 9) < 8)
          set_reg(CFG_INDEX_W'(mma_pkg::REG_WIN0 + c),
                  CFG_DATA_W'($urandom_range(1, RING_DEPTH)));
        else set_reg(CFG_INDEX_W'(mma_pkg::REG_WIN0 + c),
                     CFG_DATA_W'($urandom_range(0, 31)));
      end
      mode = p % 4;
      case (mode)
        0:       run_random(60, 0, 0);
        1:       run_random(60, 67, 0);
        2:       run_random(60, 0, 67);
        default: run_random(60, 33, 33);
      endcase
    end

    wait_idle();
    repeat (SETTLE_WAIT) @(negedge clk);
    errors += mean_expected.size();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
